// ===== hdl/kflp_pkg.sv =====
// Shared types and constants for the keyframe linear-prediction compressor.
// Used by the front end, the entry queue, the back end and the top level.
package kflp_pkg;

  localparam int PosBits     = 32;
  localparam int FrameBits   = 16;
  localparam int ThreshBits  = 31;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 32;

  // Prediction accumulator: key position plus slope times up to 2^FrameBits-1 frames.
  localparam int PredBits = PosBits + FrameBits + 2;

  localparam int QueueDepthDefault = 2;

  localparam logic [ThreshBits-1:0] ThreshReset = ThreshBits'(66);

  localparam logic [CfgIdxBits-1:0] CfgFrameCount     = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgErrorThreshold = CfgIdxBits'(1);

  // What the back end has to do with a sample.
  typedef enum logic [1:0] {
    ClsFirst,
    ClsFinal,
    ClsSlope,
    ClsPredict
  } kflp_cls_e;

  typedef struct packed {
    logic signed [PosBits-1:0] sample_x;
    logic signed [PosBits-1:0] sample_y;
    logic signed [PosBits-1:0] sample_z;
  } kflp_in_t;

  typedef struct packed {
    logic [FrameBits-1:0]      key_frame;
    logic signed [PosBits-1:0] key_x;
    logic signed [PosBits-1:0] key_y;
    logic signed [PosBits-1:0] key_z;
    logic                      last_key;
  } kflp_out_t;

  typedef struct packed {
    kflp_cls_e            cls;
    logic                 last;
    logic [FrameBits-1:0] idx;
    kflp_in_t             pos;
  } kflp_entry_t;

endpackage

// ===== hdl/kflp_front.sv =====
// Front end: accepts samples, tracks the frame number and classifies each sample.
// Depends on kflp_pkg.
module kflp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [kflp_pkg::FrameBits-1:0] frame_count_i,
  input  logic                           in_valid_i,
  input  kflp_pkg::kflp_in_t             in_data_i,
  input  logic                           queue_full_i,
  output logic                           in_stall_o,
  output logic                           push_o,
  output kflp_pkg::kflp_entry_t          entry_o
);
  import kflp_pkg::*;

  logic [FrameBits-1:0] sample_index_q, sample_index_d;
  logic                 accept;
  logic                 fc_zero;
  logic                 fc_one;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i & ~queue_full_i;
  assign fc_zero    = (frame_count_i == '0);
  assign fc_one     = (frame_count_i == FrameBits'(1));

  always_comb begin
    entry_o.cls  = ClsPredict;
    entry_o.last = 1'b0;
    entry_o.idx  = sample_index_q;
    entry_o.pos  = in_data_i;
    sample_index_d = sample_index_q + FrameBits'(1);
    if (sample_index_q == '0) begin
      entry_o.cls    = ClsFirst;
      entry_o.last   = fc_one;
      sample_index_d = fc_one ? '0 : FrameBits'(1);
    end else if (sample_index_q >= frame_count_i) begin
      entry_o.cls    = ClsFinal;
      entry_o.last   = 1'b1;
      sample_index_d = '0;
    end else if (sample_index_q == FrameBits'(1)) begin
      entry_o.cls = ClsSlope;
    end
    if (fc_zero) begin
      sample_index_d = '0;
    end
  end

  // A track of zero frames swallows its samples without touching the back end.
  assign push_o = accept & ~fc_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
    end else if (accept) begin
      sample_index_q <= sample_index_d;
    end
  end

endmodule

// ===== hdl/kflp_queue.sv =====
// Small register FIFO that decouples the classifying front end from the back end.
// Depends on kflp_pkg for the entry type.
module kflp_queue #(
  parameter int Depth = kflp_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  kflp_pkg::kflp_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output kflp_pkg::kflp_entry_t head_o
);
  import kflp_pkg::*;

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  kflp_entry_t        slots_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o       = (count_q == CntBits'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    next_ptr = (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hdl/kflp_back.sv =====
// Back end: holds the key, slope and running prediction, decides misses, emits keys.
// Depends on kflp_pkg.
module kflp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [kflp_pkg::ThreshBits-1:0] error_threshold_i,
  input  logic                            head_valid_i,
  input  kflp_pkg::kflp_entry_t           head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output kflp_pkg::kflp_out_t             out_data_o
);
  import kflp_pkg::*;

  localparam int ErrBits = PredBits + 1;

  logic signed [PosBits-1:0]   anchor_q [3];
  logic signed [PosBits-1:0]   prev_q   [3];
  logic signed [PosBits:0]     slope_q  [3];
  logic signed [PredBits-1:0]  pred_q   [3];
  logic signed [PosBits-1:0]   anchor_d [3];
  logic signed [PosBits:0]     slope_d  [3];
  logic signed [PredBits-1:0]  pred_d   [3];

  logic signed [PosBits-1:0]   cur       [3];
  logic signed [PosBits-1:0]   base      [3];
  logic signed [PosBits:0]     slope_new [3];
  logic signed [PredBits-1:0]  pred_restart [3];
  logic signed [PredBits-1:0]  pred_step [3];
  logic signed [ErrBits-1:0]   err       [3];
  logic signed [ErrBits-1:0]   thr_pos, thr_neg;
  logic [2:0]                  miss;
  logic                        miss_any;

  logic                        out_valid_q, out_valid_d;
  kflp_out_t                   out_q, out_d;
  logic                        emit;
  logic                        out_free;

  assign cur[0] = head_i.pos.sample_x;
  assign cur[1] = head_i.pos.sample_y;
  assign cur[2] = head_i.pos.sample_z;

  assign thr_pos = {{(ErrBits - ThreshBits){1'b0}}, error_threshold_i};
  assign thr_neg = -thr_pos;

  // Per axis: prediction error, the slope that a new key would give, and both
  // ways the running prediction can move on to the next frame.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      base[a]      = (head_i.cls == ClsSlope) ? anchor_q[a] : prev_q[a];
      slope_new[a] = {cur[a][PosBits-1], cur[a]} - {base[a][PosBits-1], base[a]};
      pred_restart[a] = {{(PredBits - PosBits){cur[a][PosBits-1]}}, cur[a]}
                      + {{(PredBits - PosBits - 1){slope_new[a][PosBits]}}, slope_new[a]};
      pred_step[a] = pred_q[a]
                   + {{(PredBits - PosBits - 1){slope_q[a][PosBits]}}, slope_q[a]};
      err[a] = {pred_q[a][PredBits-1], pred_q[a]}
             - {{(ErrBits - PosBits){cur[a][PosBits-1]}}, cur[a]};
      miss[a] = (err[a] > thr_pos) || (err[a] < thr_neg);
    end
  end

  assign miss_any = |miss;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = head_valid_i & out_free;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      anchor_d[a] = anchor_q[a];
      slope_d[a]  = slope_q[a];
      pred_d[a]   = pred_q[a];
    end
    emit            = 1'b0;
    out_d           = out_q;
    out_d.key_frame = head_i.idx;
    out_d.key_x     = cur[0];
    out_d.key_y     = cur[1];
    out_d.key_z     = cur[2];
    out_d.last_key  = head_i.last;
    unique case (head_i.cls)
      ClsFirst: begin
        emit = 1'b1;
        for (int a = 0; a < 3; a++) begin
          anchor_d[a] = cur[a];
        end
      end
      ClsFinal: begin
        emit = 1'b1;
      end
      ClsSlope: begin
        for (int a = 0; a < 3; a++) begin
          slope_d[a] = slope_new[a];
          pred_d[a]  = pred_restart[a];
        end
      end
      ClsPredict: begin
        if (miss_any) begin
          // The previous sample becomes the key, one frame before this one.
          emit            = 1'b1;
          out_d.key_frame = head_i.idx - FrameBits'(1);
          out_d.key_x     = prev_q[0];
          out_d.key_y     = prev_q[1];
          out_d.key_z     = prev_q[2];
          out_d.last_key  = 1'b0;
          for (int a = 0; a < 3; a++) begin
            anchor_d[a] = prev_q[a];
            slope_d[a]  = slope_new[a];
            pred_d[a]   = pred_restart[a];
          end
        end else begin
          for (int a = 0; a < 3; a++) begin
            pred_d[a] = pred_step[a];
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int a = 0; a < 3; a++) begin
        anchor_q[a] <= anchor_d[a];
        slope_q[a]  <= slope_d[a];
        pred_q[a]   <= pred_d[a];
        if (head_i.cls != ClsFinal) begin
          prev_q[a] <= cur[a];
        end
      end
      if (emit) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/keyframe_linear_predict_compress_core.sv =====
// Keyframe reduction of a 3-D position track by linear extrapolation.
// Throughput: one sample per cycle while the entry queue has room; the back end settles
// one sample per cycle on its state unless a key waits on a stalled output. A sample is
// registered in the entry queue, its key then in the output register, held while stalled.
// Reset: frame counter back to frame 0, queue and output empty, frame_count 0 and
// error_threshold 66 (about 0.001 in Q15.16).
module keyframe_linear_predict_compress_core #(
  parameter int QueueDepth = kflp_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes: index 0 is frame_count, index 1 is error_threshold.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kflp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [kflp_pkg::CfgDataBits-1:0] cfg_data_i,
  // Sample beats in.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  kflp_pkg::kflp_in_t               in_data_i,
  // Key beats out.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output kflp_pkg::kflp_out_t              out_data_o
);
  import kflp_pkg::*;

  logic [FrameBits-1:0]  frame_count_q;
  logic [ThreshBits-1:0] error_threshold_q;

  logic                  push;
  kflp_entry_t           entry;
  logic                  queue_full;
  logic                  pop;
  logic                  head_valid;
  kflp_entry_t           head;

  // Configuration is always accepted; unknown indexes are dropped. The frame
  // count is taken modulo the frame counter width.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q     <= '0;
      error_threshold_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameCount: begin
          frame_count_q <= cfg_data_i[FrameBits-1:0];
        end
        CfgErrorThreshold: begin
          error_threshold_q <= cfg_data_i[ThreshBits-1:0];
        end
        default: begin
          frame_count_q <= frame_count_q;
        end
      endcase
    end
  end

  // The front end only needs the frame number to decide what each sample is:
  // first key, final key, slope setup or a prediction check. That lets it run
  // ahead of the back end, which is the only part that waits on the output.
  kflp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_count_i (frame_count_q),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .queue_full_i  (queue_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .entry_o       (entry)
  );

  kflp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back end keeps a running prediction per axis that advances by the slope
  // each frame, so no multiplication is needed: a miss is one wide subtract and
  // a compare against the threshold on each axis.
  kflp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .error_threshold_i (error_threshold_q),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_o        (out_data_o)
  );

endmodule

// ===== dv/keyframe_linear_predict_compress_core_tb.sv =====
// Self-checking testbench for keyframe_linear_predict_compress_core.
// Depends on kflp_pkg for the beat types and the register indexes; keys are predicted
// by a behavioral track model kept in this file and checked beat by beat.
module keyframe_linear_predict_compress_core_tb;
  import kflp_pkg::*;

  // No beat of any kind for this many cycles means the block is hung.
  localparam int QuietLimit = 3000;
  // Cycles a drained block is given to retire samples that make no key.
  localparam int SettleCycles = 8;
  // Indexes past the register list; writes to them must be dropped.
  localparam logic [CfgIdxBits-1:0] CfgSpareA = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CfgSpareB = CfgIdxBits'(3);

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  kflp_in_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  kflp_out_t              out_data_o;

  keyframe_linear_predict_compress_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Track model: register copies and the state of the track being reduced.
  logic [FrameBits-1:0]         set_frames;
  logic [ThreshBits-1:0]        set_tol;
  logic signed [PosBits-1:0]    anchor_at [3];
  logic [FrameBits-1:0]         anchor_no;
  logic signed [PosBits-1:0]    prior_at [3];
  logic signed [PosBits:0]      rate_per_frame [3];
  logic [FrameBits-1:0]         frame_no;

  kflp_out_t keys_pending [$];
  int        mismatches   = 0;
  int        items_sent   = 0;
  int        quiet_cycles = 0;
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        hold_len     = 0;
  bit        hold_req     = 1'b0;

  // Motion of the synthetic track: base + rate * frame + jitter, with the odd jump.
  int motion_base [3];
  int motion_rate [3];
  int jitter_span;

  // True when the straight-line guess for one axis is off by more than the tolerance.
  // The product never exceeds 49 bits here, so 64-bit arithmetic is exact.
  function automatic bit misses_tol(logic signed [PosBits-1:0] anchor,
                                    logic signed [PosBits:0] rate,
                                    logic [FrameBits-1:0] span,
                                    logic signed [PosBits-1:0] cur);
    longint drift;
    longint gap;
    drift = longint'(rate) * longint'(span);
    gap   = longint'(anchor) - longint'(cur) + drift;
    if (gap < 0) gap = -gap;
    return gap > longint'(set_tol);
  endfunction

  // Advances the track model by one sample and reports the key it produces, if any.
  function automatic void predict_key(kflp_in_t s, output bit has_key, output kflp_out_t key);
    logic signed [PosBits-1:0] cur [3];
    bit off;
    cur[0]  = s.sample_x;
    cur[1]  = s.sample_y;
    cur[2]  = s.sample_z;
    has_key = 1'b0;
    key     = '0;
    off     = 1'b0;
    if (set_frames == '0) begin
      // An empty track swallows samples and never leaves frame 0.
      frame_no = '0;
    end else if (frame_no == '0) begin
      for (int a = 0; a < 3; a++) begin
        anchor_at[a] = cur[a];
        prior_at[a]  = cur[a];
      end
      anchor_no = '0;
      key       = '{'0, cur[0], cur[1], cur[2], set_frames == FrameBits'(1)};
      has_key   = 1'b1;
      frame_no  = (set_frames == FrameBits'(1)) ? '0 : FrameBits'(1);
    end else if (frame_no >= set_frames) begin
      // The final sample, or one past a frame count that was lowered mid-track.
      key      = '{frame_no, cur[0], cur[1], cur[2], 1'b1};
      has_key  = 1'b1;
      frame_no = '0;
    end else if (frame_no == FrameBits'(1)) begin
      for (int a = 0; a < 3; a++) begin
        rate_per_frame[a] = (PosBits+1)'(cur[a]) - (PosBits+1)'(anchor_at[a]);
        prior_at[a]       = cur[a];
      end
      frame_no = FrameBits'(2);
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (misses_tol(anchor_at[a], rate_per_frame[a], frame_no - anchor_no, cur[a])) off = 1'b1;
      end
      if (off) begin
        // The previous sample becomes the key and the slope restarts from it.
        for (int a = 0; a < 3; a++) begin
          anchor_at[a]      = prior_at[a];
          rate_per_frame[a] = (PosBits+1)'(cur[a]) - (PosBits+1)'(prior_at[a]);
        end
        anchor_no = frame_no - FrameBits'(1);
        key       = '{anchor_no, prior_at[0], prior_at[1], prior_at[2], 1'b0};
        has_key   = 1'b1;
      end
      for (int a = 0; a < 3; a++) prior_at[a] = cur[a];
      frame_no = frame_no + FrameBits'(1);
    end
  endfunction

  // Directed plan: register writes and samples; some rows carry the key typed in.
  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] reg_idx;
    logic [CfgDataBits-1:0] reg_val;
    kflp_in_t              smp;
    bit                    typed;
    bit                    typed_has;
    kflp_out_t             typed_key;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t wr(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    plan_row_t r;
    r         = '{kind: RowWrite, default: '0};
    r.kind    = RowWrite;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    plan_row_t r;
    r      = '{kind: RowSample, default: '0};
    r.kind = RowSample;
    r.smp  = '{x, y, z};
    return r;
  endfunction

  function automatic plan_row_t pt_fixed(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         bit has, kflp_out_t k);
    plan_row_t r;
    r           = pt(x, y, z);
    r.typed     = 1'b1;
    r.typed_has = has;
    r.typed_key = k;
    return r;
  endfunction

  function automatic kflp_out_t kf(logic [15:0] f, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, bit last);
    return '{f, x, y, z, last};
  endfunction

  // A point of the synthetic track at frame t; now and then pure noise or a jump.
  function automatic kflp_in_t track_point(int t);
    int v [3];
    if ($urandom_range(99) < 4) return kflp_in_t'({$urandom, $urandom, $urandom});
    for (int a = 0; a < 3; a++) begin
      v[a] = motion_base[a] + motion_rate[a] * t
             + int'($urandom_range(0, 2 * jitter_span)) - jitter_span;
    end
    if ($urandom_range(99) < 8) v[$urandom_range(2)] += int'($urandom >> $urandom_range(0, 24));
    return '{v[0], v[1], v[2]};
  endfunction

  // Register write; the caller has made sure the block is idle.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFrameCount:     set_frames = val[FrameBits-1:0];
      CfgErrorThreshold: set_tol    = val[ThreshBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Waits until every key has come back, then lets keyless samples drain out.
  task automatic settle();
    in_valid_i = 1'b0;
    while (keys_pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Offers one sample beat and books its key once the beat is taken. Valid is left
  // high on return so that back-to-back beats keep it up without a gap.
  task automatic offer_sample(kflp_in_t s, bit typed, bit typed_has, kflp_out_t typed_key);
    bit        has;
    kflp_out_t k;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = s;
    do @(posedge clk_i); while (in_stall_o);
    predict_key(s, has, k);
    if (typed) begin
      has = typed_has;
      k   = typed_key;
    end
    if (has) keys_pending.push_back(k);
    @(negedge clk_i);
  endtask

  // One random track: fresh registers, a motion, and samples until the track closes.
  // Now and then the frame count is cut to at most the current frame partway through.
  task automatic run_track();
    int frames;
    int cut;
    int t;
    logic [ThreshBits-1:0] tol;
    case ($urandom_range(7))
      0:       tol = '0;
      1:       tol = '1;
      2, 3:    tol = ThreshReset;
      default: tol = ThreshBits'($urandom_range(0, 200));
    endcase
    frames = $urandom_range(99);
    if (frames < 4) frames = 0;
    else if (frames < 10) frames = 1;
    else if (frames < 92) frames = $urandom_range(2, 24);
    else frames = $urandom_range(25, 80);
    settle();
    write_reg(CfgErrorThreshold, {1'($urandom), tol});
    write_reg(CfgFrameCount, {16'($urandom), 16'(frames)});
    for (int a = 0; a < 3; a++) begin
      motion_base[a] = int'($urandom);
      motion_rate[a] = int'($urandom) >>> $urandom_range(6, 26);
    end
    jitter_span = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 80);
    if (frames == 0) begin
      // The block only swallows these, so they do not count as items.
      repeat ($urandom_range(1, 4)) offer_sample(track_point(0), 1'b0, 1'b0, '0);
      return;
    end
    cut = (frames >= 6 && $urandom_range(19) == 0) ? $urandom_range(2, frames - 2) : -1;
    t   = 0;
    do begin
      if (t == cut) begin
        settle();
        write_reg(CfgFrameCount, 32'($urandom_range(1, t)));
      end
      offer_sample(track_point(t), 1'b0, 1'b0, '0);
      t++;
      items_sent++;
    end while (frame_no != '0);
  endtask

  // Receiver: random stalls per phase, or one long hold-off counted here.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic flag_field(string what, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Every key beat is matched against the oldest key still owed.
  always @(posedge clk_i) begin
    kflp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (keys_pending.size() == 0) begin
        mismatches++;
        $display("%0t: key beat with none expected, expected nothing actual %h",
                 $time, out_data_o);
      end else begin
        want = keys_pending.pop_front();
        flag_field("key_frame", want.key_frame, out_data_o.key_frame);
        flag_field("key_x", want.key_x, out_data_o.key_x);
        flag_field("key_y", want.key_y, out_data_o.key_y);
        flag_field("key_z", want.key_z, out_data_o.key_z);
        flag_field("last_key", want.last_key, out_data_o.last_key);
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    set_frames  = '0;
    set_tol     = ThreshReset;
    anchor_no   = '0;
    frame_no    = '0;
    for (int a = 0; a < 3; a++) begin
      anchor_at[a]      = '0;
      prior_at[a]       = '0;
      rate_per_frame[a] = '0;
    end

    // Right after reset the frame count is zero: the sample is dropped.
    plan.push_back(pt_fixed(32'd1, 32'd2, 32'd3, 1'b0, '0));
    // A one-frame track turns every sample into a closing key at frame 0.
    plan.push_back(wr(CfgFrameCount, 32'd1));
    plan.push_back(pt_fixed(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                            1'b1, kf(16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1)));
    plan.push_back(pt_fixed(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                            1'b1, kf(16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1)));
    // Zero tolerance: an exact line passes, a sample off it makes the previous frame a key.
    // High bits of both writes must be dropped by the register masks.
    plan.push_back(wr(CfgErrorThreshold, 32'h8000_0000));
    plan.push_back(wr(CfgFrameCount, 32'hABCD_0004));
    plan.push_back(pt_fixed(32'd0, 32'd0, 32'd0, 1'b1, kf(16'd0, 32'd0, 32'd0, 32'd0, 1'b0)));
    plan.push_back(pt_fixed(32'd10, 32'd20, 32'd30, 1'b0, '0));
    plan.push_back(pt_fixed(32'd20, 32'd40, 32'd60, 1'b0, '0));
    plan.push_back(pt_fixed(32'd21, 32'd40, 32'd60, 1'b1, kf(16'd2, 32'd20, 32'd40, 32'd60, 1'b0)));
    plan.push_back(pt_fixed(32'd5, 32'd5, 32'd5, 1'b1, kf(16'd4, 32'd5, 32'd5, 32'd5, 1'b1)));
    // Longest track, widest tolerance, full-scale swings between extremes.
    plan.push_back(wr(CfgFrameCount, 32'h0000_FFFF));
    plan.push_back(wr(CfgErrorThreshold, 32'h7FFF_FFFF));
    plan.push_back(pt_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            1'b1, kf(16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0)));
    plan.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    plan.push_back(pt(32'h0, 32'h0, 32'h0));
    plan.push_back(pt(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F));
    // Frame count lowered below the current frame: the next sample closes the track.
    plan.push_back(wr(CfgFrameCount, 32'd2));
    plan.push_back(pt(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333));
    // Writes past the register list change nothing.
    plan.push_back(wr(CfgSpareA, 32'hFFFF_FFFF));
    plan.push_back(wr(CfgSpareB, 32'h0));
    // Default tolerance: an error of exactly 66 passes, 67 makes a key.
    plan.push_back(wr(CfgErrorThreshold, 32'd66));
    plan.push_back(wr(CfgFrameCount, 32'd4));
    plan.push_back(pt(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    plan.push_back(pt(32'h0002_0000, 32'h0002_0000, 32'h0002_0000));
    plan.push_back(pt(32'h0003_0042, 32'h0003_0000, 32'h0003_0000));
    plan.push_back(pt(32'h0004_0043, 32'h0004_0000, 32'h0004_0000));
    plan.push_back(pt(32'h0005_0000, 32'hFFFB_0000, 32'h0005_0000));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_sample(plan[i].smp, plan[i].typed, plan[i].typed_has, plan[i].typed_key);
      end
    end

    // Random tracks in four idling phases: none, sender, receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 14 : 0;
      rx_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 14 : 0;
      while (items_sent < (phase + 1) * 240) run_track();
    end

    // Back-pressure: every sample is a key while the receiver holds off for a long
    // stretch, so the queue fills and the input stalls. The sender then pauses until
    // every key has come back.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    settle();
    write_reg(CfgFrameCount, 32'd1);
    hold_len = 100;
    hold_req = 1'b1;
    repeat (40) offer_sample(kflp_in_t'({$urandom, $urandom, $urandom}), 1'b0, 1'b0, '0);
    settle();

    // A last stretch of tracks with light idling on both sides.
    tx_idle_pct  = 14;
    rx_stall_pct = 14;
    repeat (5) run_track();
    settle();
    repeat (20) @(negedge clk_i);

    mismatches += keys_pending.size();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kflp_pkg.sv
hdl/kflp_front.sv
hdl/kflp_queue.sv
hdl/kflp_back.sv
hdl/keyframe_linear_predict_compress_core.sv
dv/keyframe_linear_predict_compress_core_tb.sv
